FILE: design/tun_pkg.sv
// ----------------------------------------------------------------------------
// tun_pkg: shared types and constants for the triangle unit normal block
// Field widths, parameter defaults and the control word carried down the pipe.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tun_pkg;

  localparam int FIELD_W            = 16;  // width of every coordinate / normal field
  localparam int COORD_BITS_DEF     = 16;
  localparam int NORM_FRAC_BITS_DEF = 14;

  // control word that travels alongside the data through the cell chain
  typedef struct packed {
    logic valid;
    logic degenerate;
  } tun_ctl_t;

endpackage

`default_nettype wire

FILE: design/tun_if.sv
// ----------------------------------------------------------------------------
// tun_if: valid/ready channels for triangles in and unit normals out
// One item moves at a clock edge where valid and ready are both high.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tun_in_if;
  import tun_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] ax, ay, az;
  logic [FIELD_W-1:0] bx, by, bz;
  logic [FIELD_W-1:0] cx, cy, cz;

  modport source (output valid, ax, ay, az, bx, by, bz, cx, cy, cz, input ready);
  modport sink   (input valid, ax, ay, az, bx, by, bz, cx, cy, cz, output ready);
endinterface

interface tun_out_if;
  import tun_pkg::*;
  logic               valid;
  logic               ready;
  logic [FIELD_W-1:0] nx, ny, nz;
  logic               degenerate;

  modport source (output valid, nx, ny, nz, degenerate, input ready);
  modport sink   (input valid, nx, ny, nz, degenerate, output ready);
endinterface

`default_nettype wire

FILE: design/triangle_unit_normal_unit.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal_unit: unit face normal of a triangle, Q8.8 in, Q1.14 out
// Cross product of (b-a) and (c-a), scaled to unit length, rounded to nearest.
// ----------------------------------------------------------------------------
//
//   channel   | dir | payload                  | handshake
//   ----------+-----+--------------------------+-------------
//   tri_in    | in  | ax ay az bx by bz cx cy cz | valid/ready
//   norm_out  | out | nx ny nz degenerate      | valid/ready
//
// Pipe: five front stages, one cell per quotient bit, one output register.
//   One item per cycle sustained while the pipe is not held.
// The whole pipe advances together; it holds only when the output register
//   is full and not taken, so tri_in.ready = !norm_out.valid || norm_out.ready.
// Synchronous reset clears the valid bits only; data registers are not reset.
// The cell chain sets the latency: each cell settles one bit of one axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module triangle_unit_normal_unit #(
  parameter int COORD_BITS     = tun_pkg::COORD_BITS_DEF,
  parameter int NORM_FRAC_BITS = tun_pkg::NORM_FRAC_BITS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  tun_in_if.sink    tri_in,
  tun_out_if.source norm_out
);
  import tun_pkg::*;

  localparam int F    = NORM_FRAC_BITS;
  localparam int QW   = F + 1;                          // quotient reaches 2^F
  localparam int W    = 4 * COORD_BITS + 2 * F + 12;    // headroom for Y << (F+2)
  localparam int EXTW = QW + FIELD_W;

  // global advance: the output register is free or being emptied
  logic adv;
  assign adv          = !norm_out.valid || norm_out.ready;
  assign tri_in.ready = adv;

  // chain position 0 is the front's output, position F+1 the last cell's
  logic signed [W-1:0] s_c   [F+2][3];
  logic signed [W-1:0] r_c   [F+2][3];
  logic signed [W-1:0] y_c   [F+2][3];
  logic [QW-1:0]       q_c   [F+2][3];
  logic                neg_c [F+2][3];
  tun_ctl_t            ctl_c [F+2];

  logic signed [W-1:0] front_s;
  logic signed [W-1:0] front_y;
  logic signed [W-1:0] front_r   [3];
  logic                front_neg [3];

  tun_front #(
    .COORD_BITS    (COORD_BITS),
    .NORM_FRAC_BITS(NORM_FRAC_BITS),
    .W             (W)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .en      (adv),
    .in_valid(tri_in.valid),
    .ax      (tri_in.ax),
    .ay      (tri_in.ay),
    .az      (tri_in.az),
    .bx      (tri_in.bx),
    .by      (tri_in.by),
    .bz      (tri_in.bz),
    .cx      (tri_in.cx),
    .cy      (tri_in.cy),
    .cz      (tri_in.cz),
    .ctl     (ctl_c[0]),
    .s       (front_s),
    .r       (front_r),
    .y       (front_y),
    .neg     (front_neg)
  );

  // seed the chain: q starts at zero, so Y = -S
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      s_c[0][j]   = front_s;
      r_c[0][j]   = front_r[j];
      y_c[0][j]   = front_y;
      q_c[0][j]   = '0;
      neg_c[0][j] = front_neg[j];
    end
  end

  // cell k decides bit F-k, most significant first
  for (genvar k = 0; k <= F; k++) begin : g_stage
    for (genvar j = 0; j < 3; j++) begin : g_axis
      tun_cell #(
        .W (W),
        .QW(QW),
        .B (F - k)
      ) u_cell (
        .clk   (clk),
        .en    (adv),
        .s_in  (s_c[k][j]),
        .r_in  (r_c[k][j]),
        .y_in  (y_c[k][j]),
        .q_in  (q_c[k][j]),
        .neg_in(neg_c[k][j]),
        .s     (s_c[k+1][j]),
        .r     (r_c[k+1][j]),
        .y     (y_c[k+1][j]),
        .q     (q_c[k+1][j]),
        .neg   (neg_c[k+1][j])
      );
    end

    // control word rides alongside the cells; reset clears valid only
    always_ff @(posedge clk) begin
      if (rst) begin
        ctl_c[k+1].valid <= 1'b0;
      end else if (adv) begin
        ctl_c[k+1] <= ctl_c[k];
      end
    end
  end

  // apply the sign and mask to the field width; degenerate forces zero
  logic [EXTW-1:0] signed_q [3];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      signed_q[j] = neg_c[F+1][j] ? -EXTW'(q_c[F+1][j]) : EXTW'(q_c[F+1][j]);
      if (ctl_c[F+1].degenerate) begin
        signed_q[j] = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      norm_out.valid <= 1'b0;
    end else if (adv) begin
      norm_out.valid <= ctl_c[F+1].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      norm_out.nx         <= signed_q[0][FIELD_W-1:0];
      norm_out.ny         <= signed_q[1][FIELD_W-1:0];
      norm_out.nz         <= signed_q[2][FIELD_W-1:0];
      norm_out.degenerate <= ctl_c[F+1].degenerate;
    end
  end

endmodule

`default_nettype wire

FILE: design/tun_front.sv
// ----------------------------------------------------------------------------
// tun_front: edge vectors, cross product, squared length and cell seeds
// Five register stages; ends with S, R = 4c^2 2^2F - S and Y = -S per axis.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tun_front #(
  parameter int COORD_BITS     = tun_pkg::COORD_BITS_DEF,
  parameter int NORM_FRAC_BITS = tun_pkg::NORM_FRAC_BITS_DEF,
  parameter int W              = 4 * COORD_BITS + 2 * NORM_FRAC_BITS + 12
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        en,
  input  wire logic                        in_valid,
  input  wire logic [tun_pkg::FIELD_W-1:0] ax, ay, az,
  input  wire logic [tun_pkg::FIELD_W-1:0] bx, by, bz,
  input  wire logic [tun_pkg::FIELD_W-1:0] cx, cy, cz,
  output tun_pkg::tun_ctl_t                ctl,
  output logic signed [W-1:0]              s,
  output logic signed [W-1:0]              r   [3],
  output logic signed [W-1:0]              y,
  output logic                             neg [3]
);
  import tun_pkg::*;

  localparam int C   = COORD_BITS;
  localparam int DW  = C + 1;
  localparam int PW  = 2 * C + 2;
  localparam int XW  = 2 * C + 3;
  localparam int MW  = 2 * C + 2;
  localparam int SQW = 2 * MW;
  localparam int SH  = 2 * NORM_FRAC_BITS + 2;

  // low C bits of each field, zero-filled when C is wider than the field
  logic signed [C-1:0] a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z;
  assign a_x = C'(ax);
  assign a_y = C'(ay);
  assign a_z = C'(az);
  assign b_x = C'(bx);
  assign b_y = C'(by);
  assign b_z = C'(bz);
  assign c_x = C'(cx);
  assign c_y = C'(cy);
  assign c_z = C'(cz);

  // stage valid bits
  logic v_a, v_b, v_c, v_d;

  // stage a: edge vectors
  logic signed [DW-1:0] ux, uy, uz, wx, wy, wz;
  // stage b: partial products
  logic signed [PW-1:0] pr [6];
  // stage c: cross product magnitude and sign
  logic [MW-1:0]        mag   [3];
  logic                 neg_c [3];
  logic                 zero_c;
  // stage d: squares
  logic [SQW-1:0]       sq    [3];
  logic                 neg_d [3];
  logic                 zero_d;

  logic signed [XW-1:0] p_comb   [3];
  logic [MW-1:0]        mag_comb [3];
  logic signed [W-1:0]  sum_comb;

  always_comb begin
    p_comb[0] = XW'(pr[0]) - XW'(pr[1]);
    p_comb[1] = XW'(pr[2]) - XW'(pr[3]);
    p_comb[2] = XW'(pr[4]) - XW'(pr[5]);
    for (int i = 0; i < 3; i++) begin
      mag_comb[i] = p_comb[i][XW-1] ? MW'(-p_comb[i]) : MW'(p_comb[i]);
    end
    sum_comb = W'(sq[0]) + W'(sq[1]) + W'(sq[2]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_a       <= 1'b0;
      v_b       <= 1'b0;
      v_c       <= 1'b0;
      v_d       <= 1'b0;
      ctl.valid <= 1'b0;
    end else if (en) begin
      v_a            <= in_valid;
      v_b            <= v_a;
      v_c            <= v_b;
      v_d            <= v_c;
      ctl.valid      <= v_d;
      ctl.degenerate <= zero_d;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ux <= DW'(b_x) - DW'(a_x);
      uy <= DW'(b_y) - DW'(a_y);
      uz <= DW'(b_z) - DW'(a_z);
      wx <= DW'(c_x) - DW'(a_x);
      wy <= DW'(c_y) - DW'(a_y);
      wz <= DW'(c_z) - DW'(a_z);

      pr[0] <= PW'(uy) * PW'(wz);
      pr[1] <= PW'(wy) * PW'(uz);
      pr[2] <= PW'(wx) * PW'(uz);
      pr[3] <= PW'(ux) * PW'(wz);
      pr[4] <= PW'(ux) * PW'(wy);
      pr[5] <= PW'(wx) * PW'(uy);

      for (int i = 0; i < 3; i++) begin
        mag[i]   <= mag_comb[i];
        neg_c[i] <= p_comb[i][XW-1];
      end
      zero_c <= (mag_comb[0] == '0) && (mag_comb[1] == '0) && (mag_comb[2] == '0);

      for (int i = 0; i < 3; i++) begin
        sq[i]    <= mag[i] * mag[i];
        neg_d[i] <= neg_c[i];
      end
      zero_d <= zero_c;

      s <= sum_comb;
      y <= -sum_comb;
      for (int i = 0; i < 3; i++) begin
        r[i]   <= (W'(sq[i]) <<< SH) - sum_comb;
        neg[i] <= neg_d[i];
      end
    end
  end

endmodule

`default_nettype wire

FILE: design/tun_cell.sv
// ----------------------------------------------------------------------------
// tun_cell: one bit of a rounded quotient c * 2^F / sqrt(S)
// Tries bit B; R and Y are updated by shifts and adds only.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tun_cell #(
  parameter int W  = 104,
  parameter int QW = 15,
  parameter int B  = 0
) (
  input  wire logic                 clk,
  input  wire logic                 en,
  input  wire logic signed [W-1:0]  s_in,
  input  wire logic signed [W-1:0]  r_in,
  input  wire logic signed [W-1:0]  y_in,
  input  wire logic [QW-1:0]        q_in,
  input  wire logic                 neg_in,
  output logic signed [W-1:0]       s,
  output logic signed [W-1:0]       r,
  output logic signed [W-1:0]       y,
  output logic [QW-1:0]             q,
  output logic                      neg
);

  // Y = (2q-1)*S, R = 4c^2 2^2F - (2q-1)^2 S
  logic signed [W-1:0] delta;
  logic                take;

  assign delta = (y_in <<< (B + 2)) + (s_in <<< (2 * B + 2));
  assign take  = (delta <= r_in);

  always_ff @(posedge clk) begin
    if (en) begin
      s   <= s_in;
      r   <= take ? r_in - delta : r_in;
      y   <= take ? y_in + (s_in <<< (B + 1)) : y_in;
      q   <= take ? (q_in | (QW'(1) << B)) : q_in;
      neg <= neg_in;
    end
  end

endmodule

`default_nettype wire

FILE: design/tun_checker.sv
// ----------------------------------------------------------------------------
// tun_checker: port-level checks on the triangle unit normal block
// Bound to the top level; sees only its ports.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tun_checker (
  input wire logic                        clk,
  input wire logic                        rst,
  input wire logic                        in_ready,
  input wire logic                        out_valid,
  input wire logic                        out_ready,
  input wire logic [tun_pkg::FIELD_W-1:0] nx,
  input wire logic [tun_pkg::FIELD_W-1:0] ny,
  input wire logic [tun_pkg::FIELD_W-1:0] nz,
  input wire logic                        degenerate
);

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a flat triangle gives a zero normal
  a_degen_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> (nx == '0) && (ny == '0) && (nz == '0))
    else $error("degenerate result with nonzero normal");

  // a proper triangle never gives an all-zero normal
  a_nondegen_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !degenerate |-> (nx != '0) || (ny != '0) || (nz != '0))
    else $error("zero normal without degenerate flag");

  // input side is only held back by a full, stalled output
  a_ready_free: assert property (@(posedge clk)
    !out_valid || out_ready |-> in_ready)
    else $error("input stalled with output free");

  // nothing comes out straight after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind triangle_unit_normal_unit tun_checker u_tun_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (tri_in.ready),
  .out_valid (norm_out.valid),
  .out_ready (norm_out.ready),
  .nx        (norm_out.nx),
  .ny        (norm_out.ny),
  .nz        (norm_out.nz),
  .degenerate(norm_out.degenerate)
);

`default_nettype wire

FILE: dv/triangle_unit_normal_unit_tb.sv
// ----------------------------------------------------------------------------
// triangle_unit_normal_unit_tb: self-checking bench for the unit normal block
// Drives triangles through the valid/ready input, predicts each unit normal
// with exact wide integer arithmetic and checks every output item in order,
// under several sender/receiver idling mixes and one long receiver hold-off.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module triangle_unit_normal_unit_tb;
  import tun_pkg::*;

  localparam int CB    = COORD_BITS_DEF;
  localparam int FB    = NORM_FRAC_BITS_DEF;
  localparam int LAT   = FB + 7;       // pipe depth: front stages, cell chain and output register
  localparam int STUCK = 5000;         // cycles with no item moving before giving up

  typedef struct {
    logic [FIELD_W-1:0] v[9];          // ax ay az bx by bz cx cy cz
  } tri_t;

  typedef struct {
    logic [FIELD_W-1:0] nx, ny, nz;
    logic               degenerate;
  } normal_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  tun_in_if  tri_in_ch ();
  tun_out_if norm_out_ch ();

  triangle_unit_normal_unit DUT (
    .clk      (clk),
    .rst      (rst),
    .tri_in   (tri_in_ch),
    .norm_out (norm_out_ch)
  );

  normal_t expected_normals[$];
  int      errors      = 0;
  int      tris_sent   = 0;
  int      normals_got = 0;
  int      degen_got   = 0;
  int      idle_cycles = 0;
  int      send_idle_pct  = 0;    // chance per item that the sender waits first
  int      recv_stall_pct = 0;    // chance per cycle that the receiver stalls
  int      hold_left      = 0;    // long receiver hold-off, counted down per cycle

  initial begin
    forever #5 clk = ~clk;
  end

  // ---- predictor -----------------------------------------------------------
  // Rounded |c| * 2^FB / sqrt(s), found bit by bit with the exact test
  // (2q-1)^2 * s <= 4 * c^2 * 2^(2FB); this is round-half-up on the magnitude.
  function automatic logic [63:0] unit_magnitude(logic [63:0] c, logic [127:0] s);
    logic [127:0] rhs, k, lhs;
    logic [63:0]  q, t;
    q   = 0;
    rhs = {64'd0, c};
    rhs = (rhs * rhs) << (2 * FB + 2);
    for (int b = FB; b >= 0; b--) begin
      t   = q | (64'd1 << b);
      k   = {64'd0, 2 * t - 1};
      lhs = k * k * s;
      if (lhs <= rhs) q = t;
    end
    return q;
  endfunction

  function automatic normal_t face_normal(tri_t t);
    normal_t      n;
    longint       pt[9];
    longint       u[3], w[3], p[3];
    logic [63:0]  mag[3], q;
    logic [127:0] sum, m;
    // sign-extend each coordinate from its low CB bits
    for (int i = 0; i < 9; i++) pt[i] = longint'($signed(t.v[i][CB-1:0]));
    for (int i = 0; i < 3; i++) begin
      u[i] = pt[3 + i] - pt[i];
      w[i] = pt[6 + i] - pt[i];
    end
    p[0] = u[1] * w[2] - w[1] * u[2];
    p[1] = w[0] * u[2] - u[0] * w[2];
    p[2] = u[0] * w[1] - w[0] * u[1];
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = p[i] < 0 ? 64'(-p[i]) : 64'(p[i]);
      m      = {64'd0, mag[i]};
      sum   += m * m;
    end
    n = '{nx: '0, ny: '0, nz: '0, degenerate: 1'b1};
    if (sum != 0) begin
      n.degenerate = 1'b0;
      q    = unit_magnitude(mag[0], sum);
      n.nx = p[0] < 0 ? FIELD_W'(-q) : FIELD_W'(q);
      q    = unit_magnitude(mag[1], sum);
      n.ny = p[1] < 0 ? FIELD_W'(-q) : FIELD_W'(q);
      q    = unit_magnitude(mag[2], sum);
      n.nz = p[2] < 0 ? FIELD_W'(-q) : FIELD_W'(q);
    end
    return n;
  endfunction

  // ---- mismatch reporting ----------------------------------------------------
  task automatic report_mismatch(string what, logic [FIELD_W-1:0] got,
                                 logic [FIELD_W-1:0] want);
    $display("[%0t] mismatch on %s: got %0h, want %0h", $time, what, got, want);
    errors++;
  endtask

  // ---- sender --------------------------------------------------------------
  // Called at a falling edge; leaves valid high on return so back-to-back
  // items never lower and raise it in the same step.
  task automatic send_tri(tri_t t);
    if ($urandom_range(99) < send_idle_pct) begin
      tri_in_ch.valid = 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
    end
    {tri_in_ch.ax, tri_in_ch.ay, tri_in_ch.az} = {t.v[0], t.v[1], t.v[2]};
    {tri_in_ch.bx, tri_in_ch.by, tri_in_ch.bz} = {t.v[3], t.v[4], t.v[5]};
    {tri_in_ch.cx, tri_in_ch.cy, tri_in_ch.cz} = {t.v[6], t.v[7], t.v[8]};
    tri_in_ch.valid = 1'b1;
    @(posedge clk);
    while (!tri_in_ch.ready) @(posedge clk);
    expected_normals.push_back(face_normal(t));
    tris_sent++;
    @(negedge clk);
  endtask

  function automatic tri_t rand_tri(int span);
    tri_t t;
    for (int i = 0; i < 9; i++)
      t.v[i] = span >= 32768 ? FIELD_W'($urandom)
                             : FIELD_W'($urandom_range(2 * span) - span);
    return t;
  endfunction

  function automatic tri_t make_tri(int a0, a1, a2, b0, b1, b2, c0, c1, c2);
    tri_t t;
    t.v = '{FIELD_W'(a0), FIELD_W'(a1), FIELD_W'(a2), FIELD_W'(b0), FIELD_W'(b1),
            FIELD_W'(b2), FIELD_W'(c0), FIELD_W'(c1), FIELD_W'(c2)};
    return t;
  endfunction

  // ---- receiver ------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_left > 0) begin
      norm_out_ch.ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      norm_out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // ---- checker and watchdog ------------------------------------------------
  always @(posedge clk) begin
    normal_t w;
    if (!rst) begin
      if (norm_out_ch.valid && norm_out_ch.ready) begin
        normals_got++;
        if (norm_out_ch.degenerate) degen_got++;
        if (expected_normals.size() == 0) begin
          $display("[%0t] normal item arrived with nothing expected", $time);
          errors++;
        end else begin
          w = expected_normals.pop_front();
          if (norm_out_ch.nx !== w.nx) report_mismatch("nx", norm_out_ch.nx, w.nx);
          if (norm_out_ch.ny !== w.ny) report_mismatch("ny", norm_out_ch.ny, w.ny);
          if (norm_out_ch.nz !== w.nz) report_mismatch("nz", norm_out_ch.nz, w.nz);
          if (norm_out_ch.degenerate !== w.degenerate)
            report_mismatch("degenerate", norm_out_ch.degenerate, w.degenerate);
        end
      end
      // a cycle counts as idle when neither channel moves an item
      if ((norm_out_ch.valid && norm_out_ch.ready) || (tri_in_ch.valid && tri_in_ch.ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STUCK) begin
        $display("timeout: no item moved for %0d cycles", STUCK);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // ---- tests ---------------------------------------------------------------
  // Extremes of the coordinates, axis-aligned faces, both windings and
  // degenerate (zero-area) triangles.
  task automatic test_directed();
    send_tri(make_tri(0, 0, 0, 0, 0, 0, 0, 0, 0));                    // all at one point
    send_tri(make_tri(0, 0, 0, 256, 0, 0, 0, 256, 0));                // +z
    send_tri(make_tri(0, 0, 0, 0, 256, 0, 256, 0, 0));                // -z
    send_tri(make_tri(0, 0, 0, 0, 256, 0, 0, 0, 256));                // +x
    send_tri(make_tri(0, 0, 0, 0, 0, 256, 256, 0, 0));                // +y
    send_tri(make_tri(10, 20, 30, 20, 40, 60, 30, 60, 90));           // collinear
    send_tri(make_tri(5, 5, 5, 5, 5, 5, 900, -3, 7));                 // a equals b
    send_tri(make_tri(-32768, -32768, -32768, 32767, -32768, -32768,
                      -32768, 32767, -32768));                        // widest edges
    send_tri(make_tri(32767, 32767, 32767, -32768, 32767, 32767,
                      32767, -32768, 32767));
    send_tri(make_tri(-32768, -32768, -32768, 32767, 32767, -32768,
                      32767, -32768, 32767));                         // huge diagonal
    send_tri(make_tri(-32768, 32767, -32768, 32767, -32768, 32767,
                      -32768, -32768, 32767));
    send_tri(make_tri(0, 0, 0, 1, 0, 0, 0, 1, 0));                    // one-lsb face
    send_tri(make_tri(0, 0, 0, 1, 1, 0, 0, 1, 1));                    // equal-ish parts
    send_tri(make_tri(0, 0, 0, 1, 0, 0, 1, 1, 1));                    // rounding ties
    send_tri(make_tri(-1, -1, -1, 0, 0, 0, 1, 1, 1));                 // collinear through 0
    send_tri(make_tri(32767, 0, 0, 0, 32767, 0, 0, 0, 32767));
    send_tri(make_tri(-32768, 0, 0, 0, -32768, 0, 0, 0, -32768));
    send_tri(make_tri(-1, -1, -1, -1, -1, -1, -1, -1, -1));
  endtask

  // Mostly full-range triangles; some small ones and some made flat on purpose.
  task automatic test_random(int count, int idle_pct, int stall_pct);
    tri_t t;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    repeat (count) begin
      case ($urandom_range(9))
        0, 1:    t = rand_tri(300);
        2: begin
          t = rand_tri(32768);
          // flat: c on a or b
          if ($urandom_range(1)) t.v[6:8] = t.v[0:2];
          else                   t.v[6:8] = t.v[3:5];
        end
        3:       t = rand_tri(4);
        default: t = rand_tri(32768);
      endcase
      send_tri(t);
    end
  endtask

  // Receiver holds off for a long stretch while items keep coming, so the
  // pipe fills and the input stalls.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_left      = 4 * LAT;
    repeat (100) send_tri(rand_tri(32768));
  endtask

  initial begin
    tri_in_ch.valid = 1'b0;
    {tri_in_ch.ax, tri_in_ch.ay, tri_in_ch.az} = '0;
    {tri_in_ch.bx, tri_in_ch.by, tri_in_ch.bz} = '0;
    {tri_in_ch.cx, tri_in_ch.cy, tri_in_ch.cz} = '0;
    norm_out_ch.ready = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_directed();
    test_random(400, 0, 0);
    test_random(400, 80, 0);
    test_random(400, 0, 80);
    test_random(400, 34, 34);
    test_backpressure();
    test_random(60, 10, 10);

    tri_in_ch.valid = 1'b0;
    recv_stall_pct  = 0;
    while (expected_normals.size() != 0) @(negedge clk);   // watchdog bounds this
    repeat (2 * LAT) @(negedge clk);

    $display("covered %0d triangles (%0d degenerate) under idle, stall and hold-off mixes",
             tris_sent, degen_got);
    $display("%0d normals checked, %0d mismatches", normals_got, errors);
    if (errors == 0 && expected_normals.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
